@@ sv/pbmd_pkg.sv @@
// Shared types and constants for the point-to-box distance core.
package pbmd_pkg;

    localparam int COORD_W = 16;
    localparam int GAP_W   = 16;
    localparam int SQ_W    = 2 * GAP_W;
    localparam int SUM_W   = 37;
    localparam int DIST_W  = 18;
    localparam int IN_W    = 3 * COORD_W;
    localparam int OUT_W   = 72;

    localparam logic [SUM_W-1:0] SUM_CAP = {1'b0, {(SUM_W-1){1'b1}}};

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic root_step;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic root_last;
    } ctrl_status_t;

endpackage

@@ sv/pbmd_datapath.sv @@
// Datapath: gap selection, squaring, saturating sums, shared square-root unit and result register.
module pbmd_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pbmd_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    input  pbmd_pkg::ctrl_cmd_t         cmd,
    output pbmd_pkg::ctrl_status_t      status,
    output logic [pbmd_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import pbmd_pkg::*;

    logic signed [COORD_W-1:0] lo, hi, x;
    logic signed [COORD_W:0]   lohi_sum, x_twice;
    logic signed [COORD_W:0]   gap_min, gap_max;
    logic signed [COORD_W:0]   neg_min, neg_max;
    logic [COORD_W-1:0]        far_sel, near_sel;

    logic [GAP_W-1:0]   abs_min_reg, abs_max_reg;
    logic [COORD_W-1:0] far_reg, near_reg;
    logic               last_reg;
    logic [SQ_W-1:0]    sq_min_reg, sq_max_reg;
    logic [SUM_W-1:0]   min_sum_reg, max_sum_reg;
    logic [SUM_W:0]     min_add, max_add;
    logic [SUM_W-1:0]   min_sat, max_sat;

    logic [SUM_W-1:0]   rad_min_reg, rad_max_reg;
    logic [SUM_W-1:0]   res_min_reg, res_max_reg;
    logic [SUM_W-1:0]   bit_reg;
    logic [SUM_W:0]     trial_min, trial_max;

    logic [COORD_W-1:0] out_far_reg, out_near_reg;
    logic [DIST_W-1:0]  out_min_reg, out_max_reg;
    logic               out_last_reg;

    assign lo       = s_tdata[COORD_W-1:0];
    assign hi       = s_tdata[2*COORD_W-1:COORD_W];
    assign x        = s_tdata[3*COORD_W-1:2*COORD_W];
    assign lohi_sum = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
    assign x_twice  = {x, 1'b0};

    // Tests run in order: at or below low, at or above high, then strictly inside.
    always_comb begin
        if (x <= lo) begin
            gap_min  = {lo[COORD_W-1], lo} - {x[COORD_W-1], x};
            gap_max  = {hi[COORD_W-1], hi} - {x[COORD_W-1], x};
            far_sel  = hi;
            near_sel = lo;
        end else if (x >= hi) begin
            gap_min  = {x[COORD_W-1], x} - {hi[COORD_W-1], hi};
            gap_max  = {x[COORD_W-1], x} - {lo[COORD_W-1], lo};
            far_sel  = lo;
            near_sel = hi;
        end else begin
            gap_min  = '0;
            near_sel = x;
            if (x_twice < lohi_sum) begin
                gap_max = {hi[COORD_W-1], hi} - {x[COORD_W-1], x};
                far_sel = hi;
            end else begin
                gap_max = {x[COORD_W-1], x} - {lo[COORD_W-1], lo};
                far_sel = lo;
            end
        end
    end

    // An inverted box can give negative gaps; only the magnitude is squared.
    assign neg_min = -gap_min;
    assign neg_max = -gap_max;

    assign min_add = {1'b0, min_sum_reg} + {{(SUM_W+1-SQ_W){1'b0}}, sq_min_reg};
    assign max_add = {1'b0, max_sum_reg} + {{(SUM_W+1-SQ_W){1'b0}}, sq_max_reg};
    assign min_sat = (min_add > {1'b0, SUM_CAP}) ? SUM_CAP : min_add[SUM_W-1:0];
    assign max_sat = (max_add > {1'b0, SUM_CAP}) ? SUM_CAP : max_add[SUM_W-1:0];

    assign trial_min = {1'b0, res_min_reg} + {1'b0, bit_reg};
    assign trial_max = {1'b0, res_max_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sum_reg <= '0;
            max_sum_reg <= '0;
        end else if (cmd.accum) begin
            if (last_reg) begin
                min_sum_reg <= '0;
                max_sum_reg <= '0;
            end else begin
                min_sum_reg <= min_sat;
                max_sum_reg <= max_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            abs_min_reg <= gap_min[COORD_W] ? neg_min[GAP_W-1:0] : gap_min[GAP_W-1:0];
            abs_max_reg <= gap_max[COORD_W] ? neg_max[GAP_W-1:0] : gap_max[GAP_W-1:0];
            far_reg     <= far_sel;
            near_reg    <= near_sel;
            last_reg    <= s_tlast;
        end
        if (cmd.square) begin
            sq_min_reg <= abs_min_reg * abs_min_reg;
            sq_max_reg <= abs_max_reg * abs_max_reg;
        end
        if (cmd.accum) begin
            rad_min_reg <= min_sat;
            rad_max_reg <= max_sat;
            res_min_reg <= '0;
            res_max_reg <= '0;
            bit_reg     <= {1'b1, {(SUM_W-1){1'b0}}};
        end else if (cmd.root_step) begin
            // One restoring step per cycle for both roots, sharing the trial bit.
            if ({1'b0, rad_min_reg} >= trial_min) begin
                rad_min_reg <= rad_min_reg - trial_min[SUM_W-1:0];
                res_min_reg <= (res_min_reg >> 1) + bit_reg;
            end else begin
                res_min_reg <= res_min_reg >> 1;
            end
            if ({1'b0, rad_max_reg} >= trial_max) begin
                rad_max_reg <= rad_max_reg - trial_max[SUM_W-1:0];
                res_max_reg <= (res_max_reg >> 1) + bit_reg;
            end else begin
                res_max_reg <= res_max_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.load) begin
            out_far_reg  <= far_reg;
            out_near_reg <= near_reg;
            out_min_reg  <= last_reg ? res_min_reg[DIST_W-1:0] : '0;
            out_max_reg  <= last_reg ? res_max_reg[DIST_W-1:0] : '0;
            out_last_reg <= last_reg;
        end
    end

    assign status.last      = last_reg;
    assign status.root_last = bit_reg[0];

    assign m_tdata = {{(OUT_W-2*COORD_W-2*DIST_W){1'b0}},
                      out_max_reg, out_min_reg, out_near_reg, out_far_reg};
    assign m_tlast = out_last_reg;

endmodule

@@ sv/pbmd_ctrl.sv @@
// Controller state machine sequencing one beat through the datapath.
module pbmd_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  pbmd_pkg::ctrl_status_t  status,
    output pbmd_pkg::ctrl_cmd_t     cmd
);
    import pbmd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_ACCUM  = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    // The result register may be refilled once its previous beat has gone or is going.
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready      = (state_reg == S_IDLE);
    assign cmd.capture   = s_tvalid && s_tready;
    assign cmd.square    = (state_reg == S_SQUARE);
    assign cmd.accum     = (state_reg == S_ACCUM);
    assign cmd.root_step = (state_reg == S_ROOT);
    assign cmd.load      = (state_reg == S_LOAD) && out_free;
    assign m_tvalid      = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SQUARE;
            end
            S_SQUARE: state_next = S_ACCUM;
            S_ACCUM: begin
                state_next = status.last ? S_ROOT : S_LOAD;
            end
            S_ROOT: begin
                if (status.root_last) state_next = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == S_SQUARE)
        else $error("accepted beat did not move to the squaring step");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while still held");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT) |-> !cmd.capture && !cmd.load)
        else $error("accept or load during square root");

endmodule

@@ sv/point_box_min_max_distance_core.sv @@
// m_tvalid rises after an accepted beat has passed the square, accumulate and load states.
// A last beat also passes the root state, in the shared restoring square-root unit, before the load.
// One beat is processed at a time: a new beat is taken only after the load state, back in idle.
// The result register lets the next beat start while a result waits for m_tready.
// aresetn is synchronous, active low: it clears the sums, the controller and m_tvalid.
module point_box_min_max_distance_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // box_low [15:0], box_high [31:16], point_coord [47:32]
    input  logic [pbmd_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // far_coord [15:0], near_coord [31:16], min_distance [49:32], max_distance [67:50], zeros
    output logic [pbmd_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import pbmd_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    pbmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbmd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

@@ bench/point_box_min_max_distance_core_tb.sv @@
// Self-checking testbench for the streaming point-to-box min/max distance core.
`timescale 1ns / 100ps

module point_box_min_max_distance_core_tb;

    import pbmd_pkg::*;

    localparam int          DIMS_NOMINAL = 16;
    localparam int          RAND_BEATS   = 700;
    localparam int unsigned RUN_LIMIT    = 500000;

    typedef struct packed {
        logic [COORD_W-1:0] far_coord;
        logic [COORD_W-1:0] near_coord;
        logic [DIST_W-1:0]  min_dist;
        logic [DIST_W-1:0]  max_dist;
        logic               last;
    } dim_result_t;

    // Tracks the running gap sums and holds the results still owed by the core.
    class distance_scoreboard;
        dim_result_t       owed_results[$];
        longint unsigned   min_gap_sum;
        longint unsigned   max_gap_sum;
        int unsigned       beats;
        int unsigned       vectors;
        int unsigned       saturated_vectors;
        int unsigned       checked;
        int unsigned       mismatches;

        function new();
            min_gap_sum       = 0;
            max_gap_sum       = 0;
            beats             = 0;
            vectors           = 0;
            saturated_vectors = 0;
            checked           = 0;
            mismatches        = 0;
        endfunction

        function automatic longint unsigned sum_sq(longint unsigned acc, int gap);
            longint g;
            longint unsigned s;
            g = gap;
            s = acc + longint'(g * g);
            if (s > SUM_CAP)
                s = 64'(SUM_CAP);
            return s;
        endfunction

        function automatic logic [DIST_W-1:0] floor_root(longint unsigned v);
            logic [DIST_W-1:0] r;
            longint unsigned   trial;
            r = '0;
            for (int b = DIST_W - 1; b >= 0; b--) begin
                trial = r | (longint'(1) << b);
                if (trial * trial <= v)
                    r = trial[DIST_W-1:0];
            end
            return r;
        endfunction

        function void note_dim(logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi,
                               logic signed [COORD_W-1:0] pt, logic last);
            int          lo_v;
            int          hi_v;
            int          pt_v;
            int          gap_min;
            int          gap_max;
            dim_result_t want;
            lo_v = lo;
            hi_v = hi;
            pt_v = pt;
            want = '0;
            // The order of the tests matters for inverted boxes.
            if (pt_v <= lo_v) begin
                gap_min         = lo_v - pt_v;
                gap_max         = hi_v - pt_v;
                want.far_coord  = hi;
                want.near_coord = lo;
            end else if (pt_v >= hi_v) begin
                gap_min         = pt_v - hi_v;
                gap_max         = pt_v - lo_v;
                want.far_coord  = lo;
                want.near_coord = hi;
            end else begin
                gap_min         = 0;
                want.near_coord = pt;
                if (2 * pt_v < lo_v + hi_v) begin
                    gap_max        = hi_v - pt_v;
                    want.far_coord = hi;
                end else begin
                    gap_max        = pt_v - lo_v;
                    want.far_coord = lo;
                end
            end
            min_gap_sum = sum_sq(min_gap_sum, gap_min);
            max_gap_sum = sum_sq(max_gap_sum, gap_max);
            want.last   = last;
            if (last) begin
                want.min_dist = floor_root(min_gap_sum);
                want.max_dist = floor_root(max_gap_sum);
                if (min_gap_sum == SUM_CAP || max_gap_sum == SUM_CAP)
                    saturated_vectors++;
                min_gap_sum = 0;
                max_gap_sum = 0;
                vectors++;
            end
            beats++;
            owed_results.push_back(want);
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic last);
            dim_result_t got;
            dim_result_t want;
            got.far_coord  = data[15:0];
            got.near_coord = data[31:16];
            got.min_dist   = data[49:32];
            got.max_dist   = data[67:50];
            got.last       = last;
            checked++;
            if (owed_results.size() == 0) begin
                if (mismatches < 10)
                    $display("Unexpected result beat %0d: far %h near %h min %0d max %0d last %b",
                             checked, got.far_coord, got.near_coord, got.min_dist,
                             got.max_dist, got.last);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got != want || data[OUT_W-1:68] != '0) begin
                if (mismatches < 10) begin
                    $display("Mismatch on result beat %0d:", checked);
                    $display("  expected far %h near %h min %0d max %0d last %b pad 0",
                             want.far_coord, want.near_coord, want.min_dist, want.max_dist,
                             want.last);
                    $display("  actual   far %h near %h min %0d max %0d last %b pad %h",
                             got.far_coord, got.near_coord, got.min_dist, got.max_dist,
                             got.last, data[OUT_W-1:68]);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;

    int unsigned        src_idle_pct  = 0;
    int unsigned        sink_idle_pct = 0;
    int unsigned        cycle_count   = 0;

    distance_scoreboard dist_board = new();

    point_box_min_max_distance_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     dist_board.owed_results.size());
            $display("point_box_min_max_distance_core_tb: FAIL");
            $finish;
        end
    end

    // Result side: check each accepted beat, then decide whether to stall the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            dist_board.check_result(m_tdata, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic send_dim(input logic [COORD_W-1:0] lo, input logic [COORD_W-1:0] hi,
                            input logic [COORD_W-1:0] pt, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pt, hi, lo};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        dist_board.note_dim(lo, hi, pt, last);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < -32768)
            return 16'h8000;
        if (v > 32767)
            return 16'h7FFF;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h8001;
            default: return 16'h7FFE;
        endcase
    endfunction

    task automatic make_dim(output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi,
                            output logic [COORD_W-1:0] pt);
        int lo_i;
        int hi_i;
        int span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // Ordered box with the point scattered just around it.
                lo_i = int'($urandom_range(0, 65535)) - 32768;
                span = $urandom_range(0, 600);
                lo   = clamp_coord(lo_i);
                hi   = clamp_coord(lo_i + span);
                pt   = clamp_coord(lo_i - 300 + int'($urandom_range(0, span + 600)));
            end
            4: begin
                // Point on or next to the midpoint, where the far corner flips.
                lo_i = int'($urandom_range(0, 30000)) - 15000;
                hi_i = lo_i + 2 * int'($urandom_range(1, 1000));
                lo   = clamp_coord(lo_i);
                hi   = clamp_coord(hi_i);
                pt   = clamp_coord((lo_i + hi_i) / 2 + int'($urandom_range(0, 2)) - 1);
            end
            5: begin
                hi_i = int'($urandom_range(0, 60000)) - 32768;
                lo   = clamp_coord(hi_i + int'($urandom_range(1, 2000)));
                hi   = clamp_coord(hi_i);
                pt   = clamp_coord(hi_i - 2000 + int'($urandom_range(0, 6000)));
            end
            6: begin
                lo = pick_extreme();
                hi = pick_extreme();
                pt = pick_extreme();
            end
            default: begin
                lo = COORD_W'($urandom_range(0, 65535));
                hi = COORD_W'($urandom_range(0, 65535));
                pt = COORD_W'($urandom_range(0, 65535));
            end
        endcase
    endtask

    task automatic send_random_vector();
        int unsigned        shape;
        int unsigned        dims;
        logic               flip;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] pt;
        shape = $urandom_range(0, 99);
        if (shape < 4) begin
            // Too many full-range gaps: both sums must clip at the cap.
            dims = $urandom_range(DIMS_NOMINAL + 1, DIMS_NOMINAL + 8);
            for (int d = 0; d < dims; d++) begin
                flip = 1'($urandom_range(0, 1));
                lo   = flip ? 16'h7FFF : 16'h8000;
                pt   = flip ? 16'h8000 : 16'h7FFF;
                send_dim(lo, lo, pt, d == dims - 1);
            end
        end else begin
            if (shape < 50)
                dims = $urandom_range(1, 4);
            else if (shape < 92)
                dims = $urandom_range(5, DIMS_NOMINAL);
            else
                dims = $urandom_range(DIMS_NOMINAL + 1, DIMS_NOMINAL + 8);
            for (int d = 0; d < dims; d++) begin
                make_dim(lo, hi, pt);
                send_dim(lo, hi, pt, d == dims - 1);
            end
        end
    endtask

    initial begin
        int unsigned directed_beats;
        src_idle_pct  = 10;
        sink_idle_pct = 62;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Box [1.0, 3.0]: below, on each bound, above, both halves and the exact midpoint.
        send_dim(16'h0100, 16'h0300, 16'hFC00, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0100, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0300, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0500, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0140, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0200, 1'b0);
        send_dim(16'h0100, 16'h0300, 16'h0280, 1'b1);
        // Inverted boxes.
        send_dim(16'h0200, 16'hFE00, 16'h0000, 1'b1);
        send_dim(16'h0200, 16'hFE00, 16'h0300, 1'b1);
        // Full-range coordinates.
        send_dim(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        send_dim(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        send_dim(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_dim(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        // Degenerate box and a midpoint tie at zero.
        send_dim(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_dim(16'hFFFF, 16'h0001, 16'h0000, 1'b1);
        directed_beats = dist_board.beats;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 10;
                    sink_idle_pct = 62;
                end
                1: begin
                    src_idle_pct  = 62;
                    sink_idle_pct = 10;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            while (dist_board.beats < directed_beats + (RAND_BEATS * (phase + 1)) / 3)
                send_random_vector();
        end
        s_tvalid <= 1'b0;
        sink_idle_pct = 0;

        while (dist_board.owed_results.size() != 0)
            @(posedge aclk);
        // A late extra beat would still be caught here.
        repeat (40) @(posedge aclk);

        $display("Sent %0d dimension beats forming %0d vectors, %0d of them with clipped sums,",
                 dist_board.beats, dist_board.vectors, dist_board.saturated_vectors);
        $display("under sender-heavy, receiver-heavy and stall-free handshake phases; %0d errors.",
                 dist_board.mismatches);
        if (dist_board.mismatches == 0 && dist_board.owed_results.size() == 0) begin
            $display("point_box_min_max_distance_core_tb: PASS");
        end else begin
            $display("point_box_min_max_distance_core_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ point_box_min_max_distance_core.f @@
sv/pbmd_pkg.sv
sv/pbmd_datapath.sv
sv/pbmd_ctrl.sv
sv/point_box_min_max_distance_core.sv
bench/point_box_min_max_distance_core_tb.sv
